[design/csrec_pkg.sv]
`default_nettype none

package csrec_pkg;

  // Fixed field widths of the stream and configuration channels
  localparam int unsigned ClipW    = 8;
  localparam int unsigned AttW     = 8;
  localparam int unsigned NowW     = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutPadW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Request kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_CLEAR = 2'd2
  } csrec_kind_e;

  // Actions reported per result
  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_CONNECT    = 2'd1,
    ACT_DISCONNECT = 2'd2,
    ACT_EVICT      = 2'd3
  } csrec_action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_ATTEMPTS    = 2'd0,
    REG_DEBOUNCE_MS     = 2'd1,
    REG_REARM_DWELL_MS  = 2'd2,
    REG_ACTIONS_ENABLED = 2'd3
  } csrec_reg_e;

  typedef struct packed {
    logic [AttW-1:0] max_attempts;
    logic [15:0]     debounce_ms;
    logic [15:0]     rearm_dwell_ms;
    logic            actions_enabled;
  } csrec_cfg_t;

  typedef struct packed {
    csrec_kind_e      kind;
    logic [ClipW-1:0] clip_index;
    logic             turn_on;
    logic             observed_on;
    logic             gated;
    logic             has_evict;
    logic [NowW-1:0]  now_ms;
  } csrec_item_t;

  typedef struct packed {
    logic [ClipW-1:0] target_clip;
    csrec_action_e    action;
    logic             released;
    logic             gave_up;
    logic             last;
  } csrec_result_t;

  // Control decisions from the update logic
  typedef struct packed {
    logic       wr_en;
    logic       set_active;
    logic       clr_active;
    logic       clr_all;
    logic [1:0] n_res;
  } csrec_ctl_t;

endpackage

`default_nettype wire

[design/csrec_ram.sv]
`default_nettype none

module csrec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/csrec_step.sv]
`default_nettype none

module csrec_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  csrec_pkg::csrec_item_t   item_i,
  input  csrec_pkg::csrec_cfg_t    cfg_i,
  input  wire logic                idx_ok_i,
  input  wire logic                active_i,
  input  wire logic                want_i,
  input  wire logic [7:0]          attempts_i,
  input  wire logic [TIME_BITS-1:0] last_time_i,
  input  wire logic                pend_i,
  input  wire logic [TIME_BITS-1:0] rearm_time_i,
  output csrec_pkg::csrec_ctl_t    ctl_o,
  output logic                     want_o,
  output logic [7:0]               attempts_o,
  output logic [TIME_BITS-1:0]     last_time_o,
  output logic                     pend_o,
  output logic [TIME_BITS-1:0]     rearm_time_o,
  output csrec_pkg::csrec_result_t res0_o,
  output csrec_pkg::csrec_result_t res1_o
);

  import csrec_pkg::*;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_rearm;
  logic [TIME_BITS-1:0] since_action;
  logic                 dwell_wait;
  logic                 debounce_wait;
  logic                 first;

  // Time differences wrap at TIME_BITS
  assign now_t         = TIME_BITS'(item_i.now_ms);
  assign since_rearm   = now_t - rearm_time_i;
  assign since_action  = now_t - last_time_i;
  assign dwell_wait    = since_rearm < TIME_BITS'(cfg_i.rearm_dwell_ms);
  assign debounce_wait = (last_time_i != '0) && (since_action < TIME_BITS'(cfg_i.debounce_ms));
  assign first         = attempts_i == '0;

  // Per-request entry update and results
  always_comb begin
    ctl_o        = '0;
    want_o       = want_i;
    attempts_o   = attempts_i;
    last_time_o  = last_time_i;
    pend_o       = pend_i;
    rearm_time_o = rearm_time_i;
    res0_o       = '{target_clip: item_i.clip_index, action: ACT_NONE,
                     released: 1'b0, gave_up: 1'b0, last: 1'b1};
    res1_o       = '{target_clip: item_i.clip_index, action: ACT_CONNECT,
                     released: 1'b0, gave_up: 1'b0, last: 1'b1};
    unique case (item_i.kind)
      KIND_EVENT: begin
        if (idx_ok_i) begin
          ctl_o.wr_en      = 1'b1;
          ctl_o.set_active = 1'b1;
          want_o           = item_i.turn_on;
          // new or changed desire restarts progress
          if (!active_i || (want_i != item_i.turn_on)) begin
            attempts_o   = '0;
            last_time_o  = '0;
            pend_o       = 1'b0;
            rearm_time_o = '0;
          end
        end
      end
      KIND_CHECK: begin
        if (idx_ok_i && active_i && cfg_i.actions_enabled) begin
          ctl_o.n_res = 2'd1;
          priority if (item_i.observed_on == want_i) begin
            ctl_o.clr_active = 1'b1;
            res0_o.released  = 1'b1;
          end else if (pend_i) begin
            if (!dwell_wait) begin
              ctl_o.wr_en   = 1'b1;
              pend_o        = 1'b0;
              last_time_o   = now_t;
              res0_o.action = ACT_DISCONNECT;
            end
          end else if (attempts_i >= cfg_i.max_attempts) begin
            ctl_o.clr_active = 1'b1;
            res0_o.released  = 1'b1;
            res0_o.gave_up   = 1'b1;
          end else if (!debounce_wait) begin
            ctl_o.wr_en = 1'b1;
            attempts_o  = attempts_i + 8'd1;
            last_time_o = now_t;
            priority if (want_i) begin
              if (first) begin
                res0_o.action = ACT_CONNECT;
              end else begin
                // re-arm: disconnect then connect
                ctl_o.n_res   = 2'd2;
                res0_o.action = ACT_DISCONNECT;
                res0_o.last   = 1'b0;
              end
            end else if (first) begin
              priority if (item_i.gated) begin
                res0_o.action = ACT_DISCONNECT;
              end else if (item_i.has_evict) begin
                res0_o.action = ACT_EVICT;
              end else begin
                res0_o.action = ACT_NONE;
              end
            end else begin
              priority if (item_i.has_evict) begin
                res0_o.action = ACT_EVICT;
              end else if (item_i.gated) begin
                pend_o        = 1'b1;
                rearm_time_o  = now_t;
                res0_o.action = ACT_CONNECT;
              end else begin
                res0_o.action = ACT_NONE;
              end
            end
          end else begin
            // debounce still running: one result with no action
          end
        end
      end
      KIND_CLEAR: begin
        ctl_o.clr_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/csrec_outq.sv]
`default_nettype none

module csrec_outq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          push_n_i,
  input  csrec_pkg::csrec_result_t res0_i,
  input  csrec_pkg::csrec_result_t res1_i,
  input  wire logic                pop_i,
  output logic [1:0]               cnt_o,
  output logic                     valid_o,
  output csrec_pkg::csrec_result_t head_o
);

  import csrec_pkg::*;

  csrec_result_t slot_q [2];
  csrec_result_t slot_d [2];
  logic [1:0]    cnt_q;
  logic [1:0]    cnt_d;
  logic [1:0]    base;

  // Shift out on pop, then append pushed results behind what remains
  always_comb begin
    slot_d = slot_q;
    base   = cnt_q - {1'b0, pop_i};
    if (pop_i) begin
      slot_d[0] = slot_q[1];
    end
    if (push_n_i != 2'd0) begin
      slot_d[base[0]] = res0_i;
    end
    if (push_n_i == 2'd2) begin
      slot_d[1] = res1_i;
    end
    cnt_d = base + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign cnt_o   = cnt_q;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = slot_q[0];

endmodule

`default_nettype wire

[design/clip_state_reconciler.sv]
// Clip state reconciler: keeps one reconcile entry per clip and emits
// connect, disconnect and evict actions to drive each clip to its wanted state.
// Input stream (s_axis): tuser is the request kind (event, check, clear),
// tdata carries the clip index, flags and the current time in ms.
// Output stream (m_axis): one result per check of an active entry while actions
// are enabled, two for a re-arm on want-on; tlast marks the final result of a check.
// Config channel: cfg_index_i / cfg_data_i written when cfg_valid_i is high;
// always ready. Write only while the block is idle.
// A request enters the input register as the entry RAM is read; the update logic
// then updates the entry and pushes its results into the result queue.
// Throughput is one request per cycle while the result queue has room; a check
// giving two results waits until the result queue is empty. The limit is the entry
// RAM's single read-modify-write per cycle, with a bypass for back-to-back hits.
// Reset clears all entries' active bits, the config to its defaults and the
// result queue; entry contents are rewritten on activation.
// When the receiver stalls, up to two results are held in the result queue;
// the update stage then holds and s_axis_tready drops.
`default_nettype none

module clip_state_reconciler #(
  parameter int unsigned CLIP_ENTRIES = 256,
  parameter int unsigned TIME_BITS    = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] clip_index, [8] turn_on, [9] observed_on, [10] gated,
  // [11] has_evict, [43:12] now_ms, [47:44] zero
  input  wire logic [csrec_pkg::InDataW-1:0]     s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] target_clip, [9:8] action, [10] released, [11] gave_up, [15:12] zero
  output logic [csrec_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [csrec_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [csrec_pkg::CfgDataW-1:0]    cfg_data_i
);

  import csrec_pkg::*;

  localparam int unsigned AddrW = $clog2(CLIP_ENTRIES);
  localparam int unsigned EntW  = 2 * TIME_BITS + AttW + 2;

  csrec_cfg_t           cfg_q;
  csrec_item_t          item_q;
  csrec_item_t          item_d;
  logic                 s1_valid_q;
  logic                 s_accept;
  logic                 s1_fire;
  logic                 room;
  logic [AddrW-1:0]     s1_addr;
  logic [AddrW-1:0]     rd_addr;
  logic                 idx_ok;
  logic                 active_rd;
  logic [CLIP_ENTRIES-1:0] active_q;

  logic [EntW-1:0]      ram_rdata;
  logic [EntW-1:0]      ent_rd;
  logic [EntW-1:0]      ent_wr;
  logic                 ram_we;
  logic                 byp_valid_q;
  logic [AddrW-1:0]     byp_addr_q;
  logic [EntW-1:0]      byp_data_q;

  logic                 ent_want;
  logic [AttW-1:0]      ent_att;
  logic [TIME_BITS-1:0] ent_last;
  logic                 ent_pend;
  logic [TIME_BITS-1:0] ent_rtime;
  logic                 new_want;
  logic [AttW-1:0]      new_att;
  logic [TIME_BITS-1:0] new_last;
  logic                 new_pend;
  logic [TIME_BITS-1:0] new_rtime;

  csrec_ctl_t           ctl;
  csrec_result_t        res0;
  csrec_result_t        res1;
  csrec_result_t        head;
  logic [1:0]           q_cnt;
  logic                 q_valid;
  logic                 q_pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_attempts: 8'd3, debounce_ms: 16'd100,
                 rearm_dwell_ms: 16'd50, actions_enabled: 1'b1};
    end else if (cfg_valid_i) begin
      unique case (csrec_reg_e'(cfg_index_i))
        REG_MAX_ATTEMPTS:    cfg_q.max_attempts    <= cfg_data_i[AttW-1:0];
        REG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data_i;
        REG_REARM_DWELL_MS:  cfg_q.rearm_dwell_ms  <= cfg_data_i;
        REG_ACTIONS_ENABLED: cfg_q.actions_enabled <= cfg_data_i[0];
      endcase
    end
  end

  // Input unpack and input register
  assign item_d = '{kind: csrec_kind_e'(s_axis_tuser),
                    clip_index: s_axis_tdata[7:0],
                    turn_on: s_axis_tdata[8],
                    observed_on: s_axis_tdata[9],
                    gated: s_axis_tdata[10],
                    has_evict: s_axis_tdata[11],
                    now_ms: s_axis_tdata[43:12]};

  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q <= item_d;
    end
  end

  // Entry store, read as the request is accepted
  assign rd_addr = AddrW'(s_axis_tdata[7:0]);
  assign ram_we  = s1_fire && ctl.wr_en;
  assign ent_wr  = {new_want, new_att, new_last, new_pend, new_rtime};

  csrec_ram #(
    .WIDTH(EntW),
    .DEPTH(CLIP_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr),
    .wdata_i(ent_wr),
    .re_i   (s_accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Bypass of the latest write covers a read issued on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (ram_we) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_addr_q <= s1_addr;
      byp_data_q <= ent_wr;
    end
  end

  assign s1_addr = AddrW'(item_q.clip_index);
  assign idx_ok  = 32'(item_q.clip_index) < 32'(CLIP_ENTRIES);
  assign ent_rd  = (byp_valid_q && (byp_addr_q == s1_addr)) ? byp_data_q : ram_rdata;
  assign {ent_want, ent_att, ent_last, ent_pend, ent_rtime} = ent_rd;
  assign active_rd = idx_ok && active_q[s1_addr];

  // Update logic
  csrec_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .idx_ok_i    (idx_ok),
    .active_i    (active_rd),
    .want_i      (ent_want),
    .attempts_i  (ent_att),
    .last_time_i (ent_last),
    .pend_i      (ent_pend),
    .rearm_time_i(ent_rtime),
    .ctl_o       (ctl),
    .want_o      (new_want),
    .attempts_o  (new_att),
    .last_time_o (new_last),
    .pend_o      (new_pend),
    .rearm_time_o(new_rtime),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  // Advance when the result queue can take all results of this request
  assign room    = ({1'b0, q_cnt} + {1'b0, ctl.n_res}) <= 3'd2;
  assign s1_fire = s1_valid_q && room;

  // Active flags, cleared at once by reset or a clear request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (s1_fire) begin
      priority if (ctl.clr_all) begin
        active_q <= '0;
      end else if (ctl.set_active) begin
        active_q[s1_addr] <= 1'b1;
      end else if (ctl.clr_active) begin
        active_q[s1_addr] <= 1'b0;
      end else begin
        active_q <= active_q;
      end
    end
  end

  // Result queue and output pack
  assign q_pop = m_axis_tvalid && m_axis_tready;

  csrec_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(s1_fire ? ctl.n_res : 2'd0),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (q_pop),
    .cnt_o   (q_cnt),
    .valid_o (q_valid),
    .head_o  (head)
  );

  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, head.gave_up, head.released, head.action,
                          head.target_clip};
  assign m_axis_tlast  = head.last;

`ifndef SYNTHESIS
  // A release leaves the entry inactive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ctl.n_res != 2'd0 && res0.released |=> !active_q[$past(s1_addr)])
    else $error("released entry still active");

  // An event on a valid index leaves the entry active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && item_q.kind == KIND_EVENT && idx_ok |=> active_q[$past(s1_addr)])
    else $error("event did not activate entry");

  // The first of two results always has its partner queued behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> q_cnt == 2'd2)
    else $error("first result of a pair without its second");

  // A check that yields two results only enters an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ctl.n_res == 2'd2 |-> q_cnt == 2'd0)
    else $error("result pair pushed into a non-empty queue");
`endif

endmodule

`default_nettype wire

[verif/tb_clip_state_reconciler.sv]
`timescale 1ns / 1ps

module tb_clip_state_reconciler;
  import csrec_pkg::*;

  localparam int unsigned Entries      = 256;
  localparam int unsigned WatchLimit   = 3000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  // Kind code the block must ignore
  localparam logic [1:0]  KIND_UNKNOWN = 2'd3;

  // Per-clip reconcile state and the actions it is expected to emit
  class clip_action_board;
    bit        active      [Entries];
    bit        want_on     [Entries];
    bit [7:0]  attempts    [Entries];
    bit [31:0] last_act_ms [Entries];
    bit        rearm_pend  [Entries];
    bit [31:0] rearm_ms    [Entries];

    bit [7:0]  max_attempts = 8'd3;
    bit [15:0] debounce_ms  = 16'd100;
    bit [15:0] dwell_ms     = 16'd50;
    bit        actions_on   = 1'b1;

    csrec_result_t expected_actions[$];
    int unsigned   mismatches;

    function int unsigned pending();
      return expected_actions.size();
    endfunction

    function void set_reg(csrec_reg_e idx, logic [15:0] val);
      case (idx)
        REG_MAX_ATTEMPTS:    max_attempts = val[7:0];
        REG_DEBOUNCE_MS:     debounce_ms  = val;
        REG_REARM_DWELL_MS:  dwell_ms     = val;
        REG_ACTIONS_ENABLED: actions_on   = val[0];
        default: ;
      endcase
    endfunction

    function void add_action(bit [7:0] clip, csrec_action_e act, bit rel, bit gave, bit fin);
      csrec_result_t res;
      res.target_clip = clip;
      res.action      = act;
      res.released    = rel;
      res.gave_up     = gave;
      res.last        = fin;
      expected_actions.insert(expected_actions.size(), res);
    endfunction

    // Update the entry table for one accepted request and queue its results
    function void note_request(csrec_item_t req);
      bit [7:0]      i;
      logic [31:0]   age;
      bit            first;
      csrec_action_e act;
      i = req.clip_index;
      case (req.kind)
        KIND_CLEAR: begin
          foreach (active[k]) active[k] = 1'b0;
        end
        KIND_EVENT: begin
          // new or changed desire restarts progress
          if (!active[i] || want_on[i] != req.turn_on) begin
            attempts[i]    = 8'd0;
            last_act_ms[i] = 32'd0;
            rearm_pend[i]  = 1'b0;
            rearm_ms[i]    = 32'd0;
          end
          active[i]  = 1'b1;
          want_on[i] = req.turn_on;
        end
        KIND_CHECK: begin
          if (!actions_on || !active[i]) return;
          if (req.observed_on == want_on[i]) begin
            active[i] = 1'b0;
            add_action(i, ACT_NONE, 1'b1, 1'b0, 1'b1);
            return;
          end
          // finish a pending re-arm once the dwell is over
          if (rearm_pend[i]) begin
            age = req.now_ms - rearm_ms[i];
            if (age < {16'd0, dwell_ms}) begin
              add_action(i, ACT_NONE, 1'b0, 1'b0, 1'b1);
            end else begin
              rearm_pend[i]  = 1'b0;
              last_act_ms[i] = req.now_ms;
              add_action(i, ACT_DISCONNECT, 1'b0, 1'b0, 1'b1);
            end
            return;
          end
          if (attempts[i] >= max_attempts) begin
            active[i] = 1'b0;
            add_action(i, ACT_NONE, 1'b1, 1'b1, 1'b1);
            return;
          end
          // zero time stamp means nothing was done yet
          age = req.now_ms - last_act_ms[i];
          if (last_act_ms[i] != 32'd0 && age < {16'd0, debounce_ms}) begin
            add_action(i, ACT_NONE, 1'b0, 1'b0, 1'b1);
            return;
          end
          first          = (attempts[i] == 8'd0);
          attempts[i]    = attempts[i] + 8'd1;
          last_act_ms[i] = req.now_ms;
          if (want_on[i]) begin
            if (!first) add_action(i, ACT_DISCONNECT, 1'b0, 1'b0, 1'b0);
            add_action(i, ACT_CONNECT, 1'b0, 1'b0, 1'b1);
          end else if (first) begin
            act = req.gated ? ACT_DISCONNECT : (req.has_evict ? ACT_EVICT : ACT_NONE);
            add_action(i, act, 1'b0, 1'b0, 1'b1);
          end else if (req.has_evict) begin
            add_action(i, ACT_EVICT, 1'b0, 1'b0, 1'b1);
          end else if (req.gated) begin
            rearm_pend[i] = 1'b1;
            rearm_ms[i]   = req.now_ms;
            add_action(i, ACT_CONNECT, 1'b0, 1'b0, 1'b1);
          end else begin
            add_action(i, ACT_NONE, 1'b0, 1'b0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result against the oldest expected action
    function void check_result(logic [15:0] data, logic last);
      csrec_result_t exp;
      logic [15:0]   exp_data;
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result clip %0d action %0d rel %0b gave %0b last %0b",
                   $time, data[7:0], data[9:8], data[10], data[11], last);
        return;
      end
      exp      = expected_actions.pop_front();
      exp_data = {4'd0, exp.gave_up, exp.released, exp.action, exp.target_clip};
      if (data !== exp_data || last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result differs: expected clip %0d action %0d rel %0b gave %0b ",
                   $time, exp.target_clip, exp.action, exp.released, exp.gave_up,
                   "last %0b, got clip %0d action %0d rel %0b gave %0b last %0b pad %h",
                   exp.last, data[7:0], data[9:8], data[10], data[11], last, data[15:12]);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic [1:0]          s_user = '0;
  logic                m_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_ready_o;

  clip_action_board sb;
  logic [31:0]      wall_ms;
  int unsigned      tx_left, rx_left, rx_count, idle_cycles;
  bit               tx_quiet, rx_quiet;

  clip_state_reconciler dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle gap per request, with stretches that run back to back
  function automatic int unsigned draw_gap(inout int unsigned left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(8, 48);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Random single bit
  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one request and wait until it is taken
  task automatic send_request(input logic [1:0] kind, input logic [7:0] clip,
                              input bit turn_on, input bit observed, input bit gated,
                              input bit evict, input logic [31:0] now_ms);
    csrec_item_t req;
    int unsigned gap;
    gap = draw_gap(tx_left, tx_quiet);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {4'd0, now_ms, evict, gated, observed, turn_on, clip};
    s_user  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    req.kind        = csrec_kind_e'(kind);
    req.clip_index  = clip;
    req.turn_on     = turn_on;
    req.observed_on = observed;
    req.gated       = gated;
    req.has_evict   = evict;
    req.now_ms      = now_ms;
    sb.note_request(req);
  endtask

  // Register write; caller drops valid after the last one
  task automatic write_reg(input csrec_reg_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Drain the block, then load a full register set
  task automatic apply_config(input bit [7:0] max_att, input bit [15:0] deb,
                              input bit [15:0] dwell, input bit en);
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    write_reg(REG_MAX_ATTEMPTS, {8'd0, max_att});
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_REARM_DWELL_MS, dwell);
    write_reg(REG_ACTIONS_ENABLED, {15'd0, en});
    cfg_valid <= 1'b0;
  endtask

  // Mostly event/check traffic on a small group of clips with advancing time
  task automatic run_random(input int unsigned count);
    int unsigned pick;
    logic [7:0]  base, clip;
    logic [31:0] step;
    bit          obs;
    base = 8'($urandom_range(0, 255));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      clip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                         : base + 8'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = $urandom_range(0, 150);
        6, 7:             step = $urandom_range(0, 400);
        8:                step = $urandom_range(0, 70000);
        default:          step = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 90);
      endcase
      wall_ms += step;
      if (pick < 18) begin
        send_request(KIND_EVENT, clip, coin(), coin(), coin(), coin(), wall_ms);
      end else if (pick < 94) begin
        obs = (sb.active[clip] && $urandom_range(0, 4) != 0) ? !sb.want_on[clip] : coin();
        send_request(KIND_CHECK, clip, coin(), obs, coin(), coin(), wall_ms);
      end else if (pick < 97) begin
        send_request(KIND_CLEAR, clip, coin(), coin(), coin(), coin(), wall_ms);
      end else begin
        send_request(KIND_UNKNOWN, clip, coin(), coin(), coin(), coin(), $urandom);
      end
    end
  endtask

  // Result side: random stalls, two long hold-offs to back up the input
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_gap(rx_left, rx_quiet);
      if (rx_count == 150 || rx_count == 600) gap = HoldCycles;
      if (gap != 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_ready));
      sb.check_result(m_axis_tdata, m_axis_tlast);
      rx_count++;
    end
  end

  // Watchdog: too long without any request moving on any channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchLimit) begin
      @(posedge clk);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("clip_state_reconciler: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    wall_ms = 32'd5000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // check of an entry that was never activated
    send_request(KIND_CHECK, 8'd5, 1'b0, 1'b1, 1'b0, 1'b0, 32'd10);
    // want on: connect at time zero, then escalation, debounce and give-up
    send_request(KIND_EVENT, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
    send_request(KIND_CHECK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    send_request(KIND_CHECK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd10);
    send_request(KIND_CHECK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd20);
    send_request(KIND_CHECK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd110);
    send_request(KIND_CHECK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd300);
    // want off on a gated target: disconnect, re-arm, dwell, then evict
    send_request(KIND_EVENT, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 32'd900);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1000);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1200);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1210);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1250);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1400);
    send_request(KIND_CHECK, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1600);
    // eviction, then a plain target that still counts an attempt
    send_request(KIND_EVENT, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1900);
    send_request(KIND_CHECK, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b1, 32'd2000);
    send_request(KIND_CHECK, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 32'd2200);
    // same desire keeps progress; matching state releases
    send_request(KIND_EVENT, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2250);
    send_request(KIND_CHECK, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b1, 32'd2300);
    // changed desire restarts; debounce across the time wrap
    send_request(KIND_EVENT, 8'd3, 1'b1, 1'b0, 1'b0, 1'b0, 32'd2400);
    send_request(KIND_EVENT, 8'd3, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2410);
    send_request(KIND_CHECK, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0);
    send_request(KIND_CHECK, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0010);
    // clear drops all entries; unknown kind is ignored
    send_request(KIND_CLEAR, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    send_request(KIND_CHECK, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_request(KIND_UNKNOWN, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);

    // random phases, each under its own register set
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: ;
        1: apply_config(8'd0, 16'd0, 16'd0, 1'b1);
        2: apply_config(8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        3: apply_config(8'($urandom_range(1, 6)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(0, 200)), 1'b1);
        4: apply_config(8'd2, 16'd20, 16'd30, 1'b0);
        5: apply_config(8'($urandom_range(1, 255)), 16'($urandom_range(0, 2000)),
                        16'($urandom_range(0, 2000)), 1'b1);
        default: apply_config(8'd3, 16'd100, 16'd50, 1'b1);
      endcase
      run_random((phase == 4) ? 80 : 200);
    end

    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (sb.mismatches == 0)
      $display("clip_state_reconciler: match");
    else
      $display("clip_state_reconciler: mismatch");
    $finish;
  end

endmodule
